// ----- src/prxc_pkg.sv -----
// Shared types and constants for the point rotation unit.
// Holds the item structs, the per-cell configuration struct and the register index codes.
// Depends on nothing.
`timescale 1ns / 1ps

package prxc_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int TRIG_WIDTH  = 16;
    localparam int COEF_WIDTH  = TRIG_WIDTH + 1;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_CENTRE_X    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTRE_Y    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTRE_Z    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIG_ABOUT_X = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIG_ABOUT_Y = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIG_ABOUT_Z = 3'd5;

    localparam logic [CFG_DATA_W-1:0] TRIG_RESET = 32'h4000_0000;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [COEF_WIDTH-1:0]  t_coef;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        t_coord point_z;
    } t_point_in;

    typedef struct packed {
        t_coord rotated_x;
        t_coord rotated_y;
        t_coord rotated_z;
        logic   saturated;
    } t_point_out;

    typedef struct packed {
        t_coord a;
        t_coord b;
        t_coord p;
        logic   sat;
    } t_lane;

    typedef struct packed {
        t_coord centre_a;
        t_coord centre_b;
        t_coef  cos_q;
        t_coef  sin_q;
    } t_cell_cfg;

endpackage

// ----- src/prxc_rot_cell.sv -----
// One plane rotation cell of the rotation chain, three register stages deep.
// Rotates lane coordinates a and b about their centres and passes p and the flag along.
// Depends on prxc_pkg.
`timescale 1ns / 1ps

module prxc_rot_cell #(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  prxc_pkg::t_lane     i_lane,
    input  prxc_pkg::t_cell_cfg i_cfg,
    output logic               o_valid,
    output prxc_pkg::t_lane     o_lane
);
    import prxc_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = DW + COEF_WIDTH;
    localparam int SW = COORD_WIDTH + TRIG_FRAC_BITS + 20;
    localparam logic signed [SW-1:0] COORD_HI = (SW'(1) <<< (COORD_WIDTH - 1)) - SW'(1);
    localparam logic signed [SW-1:0] COORD_LO = -COORD_HI - SW'(1);

    function automatic logic [COORD_WIDTH:0] scale_clamp(input logic signed [SW-1:0] s);
        logic signed [SW-1:0] q;
        logic                 sat;
        logic [COORD_WIDTH-1:0] v;
        q = s >>> TRIG_FRAC_BITS;
        if (s[SW-1] && (s[TRIG_FRAC_BITS-1:0] != '0)) begin
            q = q + SW'(1);
        end
        sat = 1'b0;
        v = q[COORD_WIDTH-1:0];
        if (q > COORD_HI) begin
            sat = 1'b1;
            v = COORD_HI[COORD_WIDTH-1:0];
        end else if (q < COORD_LO) begin
            sat = 1'b1;
            v = COORD_LO[COORD_WIDTH-1:0];
        end
        return {sat, v};
    endfunction

    logic                 r_v1, r_v2, r_v3;
    logic signed [DW-1:0] r_da, r_db;
    t_coord               r1_p, r2_p;
    logic                 r1_sat, r2_sat;
    logic signed [PW-1:0] r_p_ac, r_p_bs, r_p_bc, r_p_as;
    t_lane                r_out;

    logic signed [SW-1:0] n_sum_a, n_sum_b;
    logic [COORD_WIDTH:0] n_res_a, n_res_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_da   <= DW'(i_lane.a) - DW'(i_cfg.centre_a);
            r_db   <= DW'(i_lane.b) - DW'(i_cfg.centre_b);
            r1_p   <= i_lane.p;
            r1_sat <= i_lane.sat;

            r_p_ac <= r_da * i_cfg.cos_q;
            r_p_bs <= r_db * i_cfg.sin_q;
            r_p_bc <= r_db * i_cfg.cos_q;
            r_p_as <= r_da * i_cfg.sin_q;
            r2_p   <= r1_p;
            r2_sat <= r1_sat;

            r_out.a   <= n_res_a[COORD_WIDTH-1:0];
            r_out.b   <= n_res_b[COORD_WIDTH-1:0];
            r_out.p   <= r2_p;
            r_out.sat <= r2_sat | n_res_a[COORD_WIDTH] | n_res_b[COORD_WIDTH];
        end
    end

    always_comb begin
        n_sum_a = (SW'(i_cfg.centre_a) <<< TRIG_FRAC_BITS) + SW'(r_p_ac) + SW'(r_p_bs);
        n_sum_b = (SW'(i_cfg.centre_b) <<< TRIG_FRAC_BITS) + SW'(r_p_bc) - SW'(r_p_as);
        n_res_a = scale_clamp(n_sum_a);
        n_res_b = scale_clamp(n_sum_b);
    end

    assign o_valid = r_v3;
    assign o_lane  = r_out;

endmodule

// ----- src/point_rotate_xyz_about_centre_unit.sv -----
// Top level of the point rotation unit: configuration registers, three rotation cells, output.
// Depends on prxc_pkg and prxc_rot_cell.
`timescale 1ns / 1ps

// Rotates each 3D point about the configured centre, first about X, then Y, then Z, with
// signed Q1.14 cosine/sine pairs and saturation to the coordinate range. The block takes
// one item per clock while o_stall is low and passes it through three rotation cells of
// three register stages each (subtract, multiply, scale and clamp) and an output register.
// A skid register behind the output holds one item while the consumer stalls, with o_stall high
// while full. The user must write configuration only while the block is idle (not enforced).

module point_rotate_xyz_about_centre_unit #(
    parameter int TRIG_FRAC_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  prxc_pkg::t_point_in                 i_point,
    output logic                                o_valid,
    input  logic                                i_stall,
    output prxc_pkg::t_point_out                o_result,
    input  logic                                i_cfg_we,
    input  logic [prxc_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [prxc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import prxc_pkg::*;

    t_coord                r_centre_x, r_centre_y, r_centre_z;
    logic [CFG_DATA_W-1:0] r_trig_x, r_trig_y, r_trig_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_x <= '0;
            r_centre_y <= '0;
            r_centre_z <= '0;
            r_trig_x   <= TRIG_RESET;
            r_trig_y   <= TRIG_RESET;
            r_trig_z   <= TRIG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CENTRE_X:     r_centre_x <= i_cfg_data[COORD_WIDTH-1:0];
                REG_CENTRE_Y:     r_centre_y <= i_cfg_data[COORD_WIDTH-1:0];
                REG_CENTRE_Z:     r_centre_z <= i_cfg_data[COORD_WIDTH-1:0];
                REG_TRIG_ABOUT_X: r_trig_x   <= i_cfg_data;
                REG_TRIG_ABOUT_Y: r_trig_y   <= i_cfg_data;
                REG_TRIG_ABOUT_Z: r_trig_z   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic      w_adv;
    t_cell_cfg w_cfg_x, w_cfg_y, w_cfg_z;
    t_lane     w_in_x, w_out_x, w_in_y, w_out_y, w_in_z, w_out_z;
    logic      w_val_x, w_val_y, w_val_z;

    always_comb begin
        w_cfg_x.centre_a = r_centre_y;
        w_cfg_x.centre_b = r_centre_z;
        w_cfg_x.cos_q    = t_coef'(signed'(r_trig_x[2*TRIG_WIDTH-1:TRIG_WIDTH]));
        w_cfg_x.sin_q    = t_coef'(signed'(r_trig_x[TRIG_WIDTH-1:0]));

        w_cfg_y.centre_a = r_centre_x;
        w_cfg_y.centre_b = r_centre_z;
        w_cfg_y.cos_q    = t_coef'(signed'(r_trig_y[2*TRIG_WIDTH-1:TRIG_WIDTH]));
        w_cfg_y.sin_q    = -t_coef'(signed'(r_trig_y[TRIG_WIDTH-1:0]));

        w_cfg_z.centre_a = r_centre_x;
        w_cfg_z.centre_b = r_centre_y;
        w_cfg_z.cos_q    = t_coef'(signed'(r_trig_z[2*TRIG_WIDTH-1:TRIG_WIDTH]));
        w_cfg_z.sin_q    = t_coef'(signed'(r_trig_z[TRIG_WIDTH-1:0]));

        w_in_x.a   = i_point.point_y;
        w_in_x.b   = i_point.point_z;
        w_in_x.p   = i_point.point_x;
        w_in_x.sat = 1'b0;

        w_in_y.a   = w_out_x.p;
        w_in_y.b   = w_out_x.b;
        w_in_y.p   = w_out_x.a;
        w_in_y.sat = w_out_x.sat;

        w_in_z.a   = w_out_y.a;
        w_in_z.b   = w_out_y.p;
        w_in_z.p   = w_out_y.b;
        w_in_z.sat = w_out_y.sat;
    end

    prxc_rot_cell #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cell_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_valid(i_valid),
        .i_lane(w_in_x), .i_cfg(w_cfg_x), .o_valid(w_val_x), .o_lane(w_out_x)
    );

    prxc_rot_cell #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cell_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_valid(w_val_x),
        .i_lane(w_in_y), .i_cfg(w_cfg_y), .o_valid(w_val_y), .o_lane(w_out_y)
    );

    prxc_rot_cell #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_cell_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(w_adv), .i_valid(w_val_y),
        .i_lane(w_in_z), .i_cfg(w_cfg_z), .o_valid(w_val_z), .o_lane(w_out_z)
    );

    logic       r_out_valid, r_skid_valid;
    t_point_out r_out, r_skid;
    t_point_out w_pipe;
    logic       w_move;

    assign w_adv  = !r_skid_valid;
    assign w_move = w_val_z && w_adv;

    always_comb begin
        w_pipe.rotated_x = w_out_z.a;
        w_pipe.rotated_y = w_out_z.b;
        w_pipe.rotated_z = w_out_z.p;
        w_pipe.saturated = w_out_z.sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_move;
            end
        end else if (w_move) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= r_skid_valid ? r_skid : w_pipe;
        end else if (w_move) begin
            r_skid <= w_pipe;
        end
    end

    assign o_stall  = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ----- src/prxc_checker.sv -----
// Port-level checks for the point rotation unit, attached to the top level by bind.
// Depends on prxc_pkg and point_rotate_xyz_about_centre_unit.
`timescale 1ns / 1ps

module prxc_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input prxc_pkg::t_point_out o_result
);
    import prxc_pkg::*;

    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("Stalled result item was dropped.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_result))
        else $error("Stalled result item changed.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("Reset left an item or a stall pending.");

    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("Input stalled with no result item waiting.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall))
        else $error("Input stall raised without a stalled result item.");

endmodule

bind point_rotate_xyz_about_centre_unit prxc_checker u_prxc_checker (.*);
